/* hw/rtl/euler_to_quaternion_core_macros.svh */
// Assertion macros used by the top level of the Euler-to-quaternion core.
`ifndef EULER_TO_QUATERNION_CORE_MACROS_SVH
`define EULER_TO_QUATERNION_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define E2Q_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define E2Q_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hw/rtl/e2q_pkg.sv */
// Package with formats, constants and the arctangent table of the Euler-to-quaternion core.
package e2q_pkg;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned AtanEntries = 24;
  localparam int unsigned NumIter = (CordicSteps < AtanEntries) ? CordicSteps : AtanEntries;
  localparam int unsigned NumLanes = 3;
  localparam int unsigned ZW = 34;
  localparam int unsigned XW = 32;

  localparam logic signed [ZW-1:0] Q30Pi = 34'sd3373259426;
  localparam logic signed [ZW-1:0] Q30HalfPi = 34'sd1686629713;
  localparam logic signed [XW-1:0] Q30Gain = 32'sd652032874;

  typedef logic signed [15:0] angle_t;
  typedef logic signed [15:0] q14_t;
  typedef logic signed [17:0] q15_t;

  typedef struct packed {
    angle_t roll_angle;
    angle_t pitch_angle;
    angle_t yaw_angle;
  } in_word_t;

  typedef struct packed {
    q14_t quat_x;
    q14_t quat_y;
    q14_t quat_z;
    q14_t quat_w;
  } out_word_t;

  typedef struct packed {
    q15_t s;
    q15_t c;
  } sincos_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
    logic signed [ZW-1:0] r;
    r = '0;
    unique case (i)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043837;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543516;
      6: r = 34'sd16775851;
      7: r = 34'sd8388437;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      default: r = ZW'(signed'(35'sd1) <<< (30 - i));
    endcase
    return r;
  endfunction
endpackage

/* hw/rtl/e2q_stream_if.sv */
// Valid/ready stream interface carrying one payload word.
interface e2q_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/e2q_sincos_lane.sv */
// One lane: halved angle, quadrant fold and a pipelined CORDIC giving Q.15 sine and cosine.
module e2q_sincos_lane (
  input  logic                clk_i,
  input  logic                en_i,
  input  e2q_pkg::angle_t     angle_i,
  output e2q_pkg::sincos_t    sc_o
);
  localparam int unsigned N = e2q_pkg::NumIter;
  localparam int unsigned ZW = e2q_pkg::ZW;
  localparam int unsigned XW = e2q_pkg::XW;

  logic signed [XW-1:0] x_q [N+1];
  logic signed [XW-1:0] y_q [N+1];
  logic signed [ZW-1:0] z_q [N+1];
  logic                 flip_q [N+1];
  logic signed [ZW-1:0] z0, zf;
  logic                 fl;
  logic signed [XW:0]   xr, yr;

  // Fold the halved angle into the range of plus or minus pi/2.
  always_comb begin
    z0 = ZW'(angle_i) <<< 17;
    zf = z0;
    fl = 1'b0;
    if (z0 > e2q_pkg::Q30HalfPi) begin
      zf = z0 - e2q_pkg::Q30Pi;
      fl = 1'b1;
    end else if (z0 < -e2q_pkg::Q30HalfPi) begin
      zf = z0 + e2q_pkg::Q30Pi;
      fl = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= e2q_pkg::Q30Gain;
      y_q[0] <= '0;
      z_q[0] <= zf;
      flip_q[0] <= fl;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[i+1] <= flip_q[i];
        if (!z_q[i][ZW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - e2q_pkg::atan_q30(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + e2q_pkg::atan_q30(i);
        end
      end
    end
  end

  always_comb begin
    xr = flip_q[N] ? -(XW+1)'(x_q[N]) : (XW+1)'(x_q[N]);
    yr = flip_q[N] ? -(XW+1)'(y_q[N]) : (XW+1)'(y_q[N]);
    xr = xr + (XW+1)'(33'sd16384);
    yr = yr + (XW+1)'(33'sd16384);
    sc_o.c = xr[32:15];
    sc_o.s = yr[32:15];
  end
endmodule

/* hw/rtl/e2q_merge.sv */
// Merging stage: pair products, quaternion sums, rounding and saturation to Q1.14.
module e2q_merge (
  input  logic               clk_i,
  input  logic               en_i,
  input  e2q_pkg::sincos_t   roll_i,
  input  e2q_pkg::sincos_t   pitch_i,
  input  e2q_pkg::sincos_t   yaw_i,
  output e2q_pkg::out_word_t quat_o
);
  logic signed [35:0] cpcy_q, spcy_q, cpsy_q, spsy_q;
  logic signed [17:0] sr_q, cr_q;
  logic signed [53:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;

  function automatic e2q_pkg::q14_t to_q14(input logic signed [54:0] v);
    logic signed [54:0] t;
    logic signed [23:0] r;
    t = v + (55'sd1 <<< 30);
    r = 24'(t >>> 31);
    if (r > 24'sd16384) r = 24'sd16384;
    if (r < -24'sd16384) r = -24'sd16384;
    return r[15:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cpcy_q <= pitch_i.c * yaw_i.c;
      spcy_q <= pitch_i.s * yaw_i.c;
      cpsy_q <= pitch_i.c * yaw_i.s;
      spsy_q <= pitch_i.s * yaw_i.s;
      sr_q <= roll_i.s;
      cr_q <= roll_i.c;
      a_q <= sr_q * cpcy_q;
      b_q <= cr_q * spsy_q;
      c_q <= cr_q * spcy_q;
      d_q <= sr_q * cpsy_q;
      e_q <= cr_q * cpsy_q;
      f_q <= sr_q * spcy_q;
      g_q <= cr_q * cpcy_q;
      h_q <= sr_q * spsy_q;
      quat_o.quat_x <= to_q14(55'(a_q) - 55'(b_q));
      quat_o.quat_y <= to_q14(55'(c_q) + 55'(d_q));
      quat_o.quat_z <= to_q14(55'(e_q) - 55'(f_q));
      quat_o.quat_w <= to_q14(55'(g_q) + 55'(h_q));
    end
  end
endmodule

/* hw/rtl/euler_to_quaternion_core.sv */
// Top level of the Euler-to-quaternion core: three sine/cosine lanes and a merging stage.
//   channel  | dir | word
//   in_s     | in  | roll_angle, pitch_angle, yaw_angle (Q3.12)
//   out_m    | out | quat_x, quat_y, quat_z, quat_w (Q1.14)
// One word is taken per cycle while the output is not stalled.
// Each word passes through the input register, the unrolled CORDIC stages, the two product
// stages and the output register.
// The whole pipeline advances when the output register is empty or being taken.
// Reset clears only the valid flags of the pipeline.
`include "euler_to_quaternion_core_macros.svh"
module euler_to_quaternion_core (
  input  logic clk_i,
  input  logic rst_ni,
  e2q_stream_if.sink   in_s,
  e2q_stream_if.source out_m
);
  localparam int unsigned Lat = e2q_pkg::NumIter + 4;

  logic [Lat-1:0] vld_q;
  logic           en;
  e2q_pkg::sincos_t sc_r, sc_p, sc_y;

  assign en = !vld_q[Lat-1] || out_m.ready;
  assign in_s.ready = en;
  assign out_m.valid = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_s.valid};
    end
  end

  e2q_sincos_lane u_roll (.clk_i, .en_i(en), .angle_i(in_s.data.roll_angle), .sc_o(sc_r));
  e2q_sincos_lane u_pitch (.clk_i, .en_i(en), .angle_i(in_s.data.pitch_angle), .sc_o(sc_p));
  e2q_sincos_lane u_yaw (.clk_i, .en_i(en), .angle_i(in_s.data.yaw_angle), .sc_o(sc_y));

  e2q_merge u_merge (
    .clk_i, .en_i(en), .roll_i(sc_r), .pitch_i(sc_p), .yaw_i(sc_y), .quat_o(out_m.data)
  );

  `E2Q_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_m.valid && !out_m.ready, out_m.valid)
  `E2Q_ASSERT_IMP(a_ready_free, clk_i, rst_ni, !out_m.valid, in_s.ready)
  `E2Q_ASSERT_NEXT(a_hold_data, clk_i, rst_ni, out_m.valid && !out_m.ready,
                   $stable(out_m.data))
  `E2Q_ASSERT_IMP(a_sat_w, clk_i, rst_ni, out_m.valid,
                  out_m.data.quat_w <= 16'sd16384 && out_m.data.quat_w >= -16'sd16384)
endmodule
